// ===== hdl/stick_level_quantizer_with_dash_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef STICK_LEVEL_QUANTIZER_WITH_DASH_MACROS_SVH
`define STICK_LEVEL_QUANTIZER_WITH_DASH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define SLQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slqd assertion failed");
// Next-cycle implication, disabled during reset.
`define SLQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slqd assertion failed");
`else
`define SLQD_ASSERT_NOW(label, ante, cons)
`define SLQD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/slqd_pkg.sv =====
package slqd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int ZONE_BITS   = 10;
  localparam int TICK_BITS   = 8;
  localparam int MS_BITS     = 12;
  localparam int TIMER_BITS  = 13;
  localparam int LEVEL_BITS  = 3;
  localparam int OUT_BITS    = 4;
  localparam int SUM_BITS    = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  // signed compare width: covers centre + dead zone and supply - zone
  localparam int CMP_BITS = ((SAMPLE_BITS > ZONE_BITS) ? SAMPLE_BITS : ZONE_BITS) + 2;

  localparam logic [LEVEL_BITS-1:0] LEVEL_EDGE   = 3'd5;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIDDLE = 3'd3;
  localparam logic [LEVEL_BITS-1:0] LEVEL_NEAR   = 3'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_NONE   = 3'd0;
  localparam logic [SUM_BITS-1:0]   HIGH_SUM     = 5'd4;

  localparam logic [ZONE_BITS-1:0] DEAD_ZONE_RST   = 10'd100;
  localparam logic [ZONE_BITS-1:0] EDGE_ZONE_RST   = 10'd7;
  localparam logic [ZONE_BITS-1:0] MIDDLE_ZONE_RST = 10'd200;
  localparam logic [TICK_BITS-1:0] TICK_MS_RST     = 8'd12;
  localparam logic [MS_BITS-1:0]   TIME_CAP_RST    = 12'd4028;
  localparam logic [MS_BITS-1:0]   DASH_WINDOW_RST = 12'd300;
  localparam logic [MS_BITS-1:0]   DASH_MIN_RST    = 12'd10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEAD_ZONE   = 3'd0,
    REG_EDGE_ZONE   = 3'd1,
    REG_MIDDLE_ZONE = 3'd2,
    REG_TICK_MS     = 3'd3,
    REG_TIME_CAP    = 3'd4,
    REG_DASH_WINDOW = 3'd5,
    REG_DASH_MIN    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] supply_sample;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] left_level;
    logic [OUT_BITS-1:0] right_level;
    logic [OUT_BITS-1:0] down_level;
    logic [OUT_BITS-1:0] up_level;
  } out_beat_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] low;
    logic [LEVEL_BITS-1:0] high;
  } grade_t;

  // Grade one axis sample against supply v; centre is v/2.
  function automatic grade_t grade(input logic [SAMPLE_BITS-1:0] v,
                                   input logic [SAMPLE_BITS-1:0] a,
                                   input logic [ZONE_BITS-1:0] dz,
                                   input logic [ZONE_BITS-1:0] ez,
                                   input logic [ZONE_BITS-1:0] mz);
    logic signed [CMP_BITS-1:0] sv;
    logic signed [CMP_BITS-1:0] sa;
    logic signed [CMP_BITS-1:0] sc;
    logic signed [CMP_BITS-1:0] sdz;
    logic signed [CMP_BITS-1:0] sez;
    logic signed [CMP_BITS-1:0] smz;
    grade_t g;
    sv  = signed'({{(CMP_BITS-SAMPLE_BITS){1'b0}}, v});
    sa  = signed'({{(CMP_BITS-SAMPLE_BITS){1'b0}}, a});
    sdz = signed'({{(CMP_BITS-ZONE_BITS){1'b0}}, dz});
    sez = signed'({{(CMP_BITS-ZONE_BITS){1'b0}}, ez});
    smz = signed'({{(CMP_BITS-ZONE_BITS){1'b0}}, mz});
    sc  = sv >>> 1;
    if (sa < sez)            g.low = LEVEL_EDGE;
    else if (sa < smz)       g.low = LEVEL_MIDDLE;
    else if (sa < sc - sdz)  g.low = LEVEL_NEAR;
    else                     g.low = LEVEL_NONE;
    if (sv - sez < sa)       g.high = LEVEL_EDGE;
    else if (sv - smz < sa)  g.high = LEVEL_MIDDLE;
    else if (sc + sdz < sa)  g.high = LEVEL_NEAR;
    else                     g.high = LEVEL_NONE;
    return g;
  endfunction

  // Level to output field, doubled in dash.
  function automatic logic [OUT_BITS-1:0] scale(input logic [LEVEL_BITS-1:0] lvl,
                                                input logic dash);
    return dash ? {lvl, 1'b0} : {1'b0, lvl};
  endfunction

endpackage

// ===== hdl/stick_level_quantizer_with_dash.sv =====
// Stick level quantizer with dash. Each input beat carries a supply sample and the
// X/Y stick samples; each axis is graded against half the supply into a low-side and
// a high-side level (0, 1, 3 or 5) using the dead, middle and edge zones. Two
// saturating millisecond timers (X off centre, level sum below 4) decide when dash
// mode starts; in dash all four levels are doubled, and dash ends on the first beat
// whose sum is below 4. Exactly one result beat comes out per input beat, in order.
// A beat accepted into the input register is graded into the result register at the
// first edge at which the result register is empty or being drained; throughput is
// one beat per cycle while the output does not stall, set by the single grading and
// timer-update stage between the two registers. Configuration is through a plain
// write port (cfg_we, cfg_index, cfg_data) and must only be written while idle;
// unknown indexes are ignored.
`include "stick_level_quantizer_with_dash_macros.svh"

module stick_level_quantizer_with_dash (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [slqd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [slqd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  slqd_pkg::in_beat_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output slqd_pkg::out_beat_t                    out_data
);

  // configuration registers
  logic [slqd_pkg::ZONE_BITS-1:0] dead_zone;
  logic [slqd_pkg::ZONE_BITS-1:0] edge_zone;
  logic [slqd_pkg::ZONE_BITS-1:0] middle_zone;
  logic [slqd_pkg::TICK_BITS-1:0] tick_ms;
  logic [slqd_pkg::MS_BITS-1:0]   time_cap_ms;
  logic [slqd_pkg::MS_BITS-1:0]   dash_window_ms;
  logic [slqd_pkg::MS_BITS-1:0]   dash_min_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone      <= slqd_pkg::DEAD_ZONE_RST;
      edge_zone      <= slqd_pkg::EDGE_ZONE_RST;
      middle_zone    <= slqd_pkg::MIDDLE_ZONE_RST;
      tick_ms        <= slqd_pkg::TICK_MS_RST;
      time_cap_ms    <= slqd_pkg::TIME_CAP_RST;
      dash_window_ms <= slqd_pkg::DASH_WINDOW_RST;
      dash_min_ms    <= slqd_pkg::DASH_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slqd_pkg::REG_DEAD_ZONE:   dead_zone      <= cfg_data[slqd_pkg::ZONE_BITS-1:0];
        slqd_pkg::REG_EDGE_ZONE:   edge_zone      <= cfg_data[slqd_pkg::ZONE_BITS-1:0];
        slqd_pkg::REG_MIDDLE_ZONE: middle_zone    <= cfg_data[slqd_pkg::ZONE_BITS-1:0];
        slqd_pkg::REG_TICK_MS:     tick_ms        <= cfg_data[slqd_pkg::TICK_BITS-1:0];
        slqd_pkg::REG_TIME_CAP:    time_cap_ms    <= cfg_data[slqd_pkg::MS_BITS-1:0];
        slqd_pkg::REG_DASH_WINDOW: dash_window_ms <= cfg_data[slqd_pkg::MS_BITS-1:0];
        slqd_pkg::REG_DASH_MIN:    dash_min_ms    <= cfg_data[slqd_pkg::MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic               s1_valid;
  slqd_pkg::in_beat_t s1_data;
  logic               s1_advance;

  // s1 moves on whenever the result register is empty or being drained
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // grading and timer update, one beat per cycle while s1 advances
  slqd_pkg::grade_t gx;
  slqd_pkg::grade_t gy;
  logic [slqd_pkg::SUM_BITS-1:0]   level_sum;
  logic                            sum_high;
  logic                            x_centred;
  logic [slqd_pkg::TIMER_BITS-1:0] off_centre_time;
  logic [slqd_pkg::TIMER_BITS-1:0] off_centre_time_next;
  logic [slqd_pkg::TIMER_BITS-1:0] below_high_time;
  logic [slqd_pkg::TIMER_BITS-1:0] below_high_time_next;
  logic                            dash_active;
  logic                            dash_active_next;
  logic [slqd_pkg::TIMER_BITS-1:0] cap_ext;
  logic [slqd_pkg::TIMER_BITS-1:0] tick_ext;
  logic [slqd_pkg::TIMER_BITS-1:0] window_ext;
  logic [slqd_pkg::TIMER_BITS-1:0] min_ext;
  slqd_pkg::out_beat_t             result;

  assign cap_ext    = {1'b0, time_cap_ms};
  assign window_ext = {1'b0, dash_window_ms};
  assign min_ext    = {1'b0, dash_min_ms};
  assign tick_ext   = {{(slqd_pkg::TIMER_BITS-slqd_pkg::TICK_BITS){1'b0}}, tick_ms};

  always_comb begin
    gx = slqd_pkg::grade(s1_data.supply_sample, s1_data.x_sample,
                         dead_zone, edge_zone, middle_zone);
    gy = slqd_pkg::grade(s1_data.supply_sample, s1_data.y_sample,
                         dead_zone, edge_zone, middle_zone);
    level_sum = {2'b00, gx.low} + {2'b00, gx.high} + {2'b00, gy.low} + {2'b00, gy.high};
    sum_high  = (level_sum >= slqd_pkg::HIGH_SUM);
    x_centred = (gx.low == slqd_pkg::LEVEL_NONE) && (gx.high == slqd_pkg::LEVEL_NONE);

    // X off-centre timer: cleared when centred, stops counting once at or past the cap
    if (x_centred) begin
      off_centre_time_next = '0;
    end else if (off_centre_time < cap_ext) begin
      off_centre_time_next = off_centre_time + tick_ext;
    end else begin
      off_centre_time_next = off_centre_time;
    end

    // dash start looks at the updated X timer but the old below-4 timer
    if (sum_high) begin
      dash_active_next = dash_active ||
                         ((off_centre_time_next < window_ext) &&
                          (min_ext < below_high_time) &&
                          (below_high_time < window_ext));
      below_high_time_next = '0;
    end else begin
      dash_active_next = 1'b0;
      if (below_high_time < cap_ext) begin
        below_high_time_next = below_high_time + tick_ext;
      end else begin
        below_high_time_next = below_high_time;
      end
    end

    // dash_active_next is only ever high with a high sum
    result.left_level  = slqd_pkg::scale(gx.low,  dash_active_next);
    result.right_level = slqd_pkg::scale(gx.high, dash_active_next);
    result.down_level  = slqd_pkg::scale(gy.low,  dash_active_next);
    result.up_level    = slqd_pkg::scale(gy.high, dash_active_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_centre_time <= '0;
      below_high_time <= '0;
      dash_active     <= 1'b0;
    end else if (s1_advance) begin
      off_centre_time <= off_centre_time_next;
      below_high_time <= below_high_time_next;
      dash_active     <= dash_active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result;
    end
  end

  // checks
  `SLQD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `SLQD_ASSERT_NEXT(a_dash_ends_low_sum, s1_advance && !sum_high, !dash_active)
  `SLQD_ASSERT_NEXT(a_below_clear_high_sum, s1_advance && sum_high, below_high_time == '0)
  `SLQD_ASSERT_NEXT(a_dash_levels_even, s1_advance && dash_active_next,
                    !out_data.left_level[0] && !out_data.right_level[0] &&
                    !out_data.down_level[0] && !out_data.up_level[0])

endmodule

// ===== bench/stick_level_quantizer_with_dash_test.sv =====
module stick_level_quantizer_with_dash_test;
  import slqd_pkg::*;

  // Settle margin waited after the last predicted result beat has come back.
  localparam int SETTLE_CYCLES = 4;
  // Cycles with no beat moving on either channel before the run is abandoned.
  localparam int IDLE_LIMIT    = 2000;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int DASH_GAIN     = 2;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {AIM_CENTRE, AIM_RAIL, AIM_ANY} aim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  stick_level_quantizer_with_dash uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: our own copy of the register file and of the two timers and
  // the dash flag. Registers only change while the block is idle, so the copy
  // is simply updated as each write is issued.
  // ---------------------------------------------------------------------------
  int zone_dead, zone_edge, zone_middle;
  int tick_step, time_cap, dash_window, dash_min;
  logic [TIMER_BITS-1:0] off_centre_ms;
  logic [TIMER_BITS-1:0] below_four_ms;
  logic                  dashing;

  out_beat_t levels_due[$];      // predicted result beats, oldest first
  in_beat_t  beats_to_send[$];

  int queued_beats   = 0;
  int accepted_beats = 0;
  int failures       = 0;
  int idle_cycles    = 0;

  // Sender pacing: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;
  // Receiver pacing: a stall style that is picked anew when its countdown runs out.
  int stall_style = 0;
  int style_left  = 0;

  out_beat_t want;

  // Grade one axis against supply v. Order of the tests matters: with
  // overlapping zones the first match wins, and both sides may be non-zero.
  function automatic void grade_axis(input int v, input int a, output int lo, output int hi);
    int c;
    c = v / 2;
    if (a < zone_edge)             lo = LEVEL_EDGE;
    else if (a < zone_middle)      lo = LEVEL_MIDDLE;
    else if (a < c - zone_dead)    lo = LEVEL_NEAR;
    else                           lo = LEVEL_NONE;
    if (v - zone_edge < a)         hi = LEVEL_EDGE;
    else if (v - zone_middle < a)  hi = LEVEL_MIDDLE;
    else if (c + zone_dead < a)    hi = LEVEL_NEAR;
    else                           hi = LEVEL_NONE;
  endfunction

  // Advance the timers and dash flag by one tick and return the levels.
  function automatic out_beat_t predict_levels(input in_beat_t b);
    int left, right, down, up;
    out_beat_t r;
    grade_axis(b.supply_sample, b.x_sample, left, right);
    grade_axis(b.supply_sample, b.y_sample, down, up);

    if (left == 0 && right == 0)
      off_centre_ms = '0;
    else if (off_centre_ms < time_cap)
      off_centre_ms = TIMER_BITS'(off_centre_ms + tick_step);  // wraps at 13 bits, never reached

    if (left + right + down + up >= HIGH_SUM) begin
      // below-4 time is the value from before this tick; off-centre is fresh
      if (!dashing && off_centre_ms < dash_window &&
          dash_min < below_four_ms && below_four_ms < dash_window)
        dashing = 1'b1;
      if (dashing) begin
        left  *= DASH_GAIN;
        right *= DASH_GAIN;
        down  *= DASH_GAIN;
        up    *= DASH_GAIN;
      end
      below_four_ms = '0;
    end else begin
      dashing = 1'b0;
      if (below_four_ms < time_cap)
        below_four_ms = TIMER_BITS'(below_four_ms + tick_step);
    end

    r.left_level  = OUT_BITS'(left);
    r.right_level = OUT_BITS'(right);
    r.down_level  = OUT_BITS'(down);
    r.up_level    = OUT_BITS'(up);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_beat(input int v, input int x, input int y);
    in_beat_t b;
    b.supply_sample = SAMPLE_BITS'(v);
    b.x_sample      = SAMPLE_BITS'(x);
    b.y_sample      = SAMPLE_BITS'(y);
    beats_to_send.push_back(b);
    queued_beats++;
  endtask

  // Sample aimed at the centre (within the dead zone), at a rail (within or
  // just outside the edge zone) or anywhere, for the current settings.
  function automatic int pick_sample(input int v, input aim_t aim);
    int a;
    case (aim)
      AIM_CENTRE: a = v / 2 + int'($urandom_range(0, 2 * zone_dead)) - zone_dead;
      AIM_RAIL: begin
        if ($urandom_range(0, 1))
          a = int'($urandom_range(0, zone_edge + 2));
        else
          a = v - int'($urandom_range(0, zone_edge + 2));
      end
      default: a = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (a < 0) a = 0;
    if (a > SAMPLE_MAX) a = SAMPLE_MAX;
    return a;
  endfunction

  // Mostly stick gestures: a quiet spell near centre, then a hard push
  // towards a rail, which is what it takes to reach dash mode. The rest is
  // raw noise that breaks those sequences up.
  task automatic queue_random(input int count);
    int made, v, quiet_len, hard_len;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 7) begin
        v = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, SAMPLE_MAX))
                                        : int'($urandom_range(512, SAMPLE_MAX));
        quiet_len = $urandom_range(0, 28);
        hard_len  = $urandom_range(1, 6);
        repeat (quiet_len) begin
          push_beat(v, pick_sample(v, AIM_CENTRE),
                    pick_sample(v, ($urandom_range(0, 3) == 0) ? AIM_ANY : AIM_CENTRE));
          made++;
        end
        repeat (hard_len) begin
          push_beat(v, pick_sample(v, ($urandom_range(0, 3) == 0) ? AIM_CENTRE : AIM_RAIL),
                    pick_sample(v, aim_t'($urandom_range(0, 2))));
          made++;
        end
      end else begin
        push_beat($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                  $urandom_range(0, SAMPLE_MAX));
        made++;
      end
    end
  endtask

  // Register write. The predictor keeps only the register's width.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DEAD_ZONE:   zone_dead   = int'(val[ZONE_BITS-1:0]);
      REG_EDGE_ZONE:   zone_edge   = int'(val[ZONE_BITS-1:0]);
      REG_MIDDLE_ZONE: zone_middle = int'(val[ZONE_BITS-1:0]);
      REG_TICK_MS:     tick_step   = int'(val[TICK_BITS-1:0]);
      REG_TIME_CAP:    time_cap    = int'(val[MS_BITS-1:0]);
      REG_DASH_WINDOW: dash_window = int'(val[MS_BITS-1:0]);
      REG_DASH_MIN:    dash_min    = int'(val[MS_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int dz, input int ez, input int mz, input int tick,
                           input int cap, input int window, input int min_ms);
    write_reg(REG_DEAD_ZONE,   CFG_DATA_BITS'(dz));
    write_reg(REG_EDGE_ZONE,   CFG_DATA_BITS'(ez));
    write_reg(REG_MIDDLE_ZONE, CFG_DATA_BITS'(mz));
    write_reg(REG_TICK_MS,     CFG_DATA_BITS'(tick));
    write_reg(REG_TIME_CAP,    CFG_DATA_BITS'(cap));
    write_reg(REG_DASH_WINDOW, CFG_DATA_BITS'(window));
    write_reg(REG_DASH_MIN,    CFG_DATA_BITS'(min_ms));
  endtask

  // Everything queued has been taken and every predicted beat has come back.
  // Counters and queues move together in the driver, so a stale read only
  // delays the wait.
  task automatic wait_drained();
    while (!(accepted_beats == queued_beats && levels_due.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: drives one beat at a time from beats_to_send. in_valid and
  // in_data get at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        levels_due.push_back(predict_levels(in_data));
        accepted_beats++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          in_data  <= beats_to_send.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // occasional long bursts give stretches without any gap
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result beat against the oldest prediction, and
  // paces out_ready in one of four styles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        $error("result beat with no prediction waiting: %h", out_data);
        failures++;
      end else begin
        want = levels_due.pop_front();
        if (out_data.left_level !== want.left_level) begin
          $error("left_level: expected %0d, got %0d", want.left_level, out_data.left_level);
          failures++;
        end
        if (out_data.right_level !== want.right_level) begin
          $error("right_level: expected %0d, got %0d", want.right_level, out_data.right_level);
          failures++;
        end
        if (out_data.down_level !== want.down_level) begin
          $error("down_level: expected %0d, got %0d", want.down_level, out_data.down_level);
          failures++;
        end
        if (out_data.up_level !== want.up_level) begin
          $error("up_level: expected %0d, got %0d", want.up_level, out_data.up_level);
          failures++;
        end
      end
    end

    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 80);
    end else begin
      style_left--;
    end
    case (stall_style)
      0: out_ready <= 1'b1;                                  // never stalls
      1: out_ready <= $urandom_range(0, 1);                  // coin toss
      2: out_ready <= ($urandom_range(0, 7) != 0);           // rare stalls
      default: out_ready <= ($urandom_range(0, 15) == 0) ? ~out_ready : out_ready;  // long runs
    endcase
  end

  // Watchdog: too long without a beat on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    zone_dead     = DEAD_ZONE_RST;
    zone_edge     = EDGE_ZONE_RST;
    zone_middle   = MIDDLE_ZONE_RST;
    tick_step     = TICK_MS_RST;
    time_cap      = TIME_CAP_RST;
    dash_window   = DASH_WINDOW_RST;
    dash_min      = DASH_MIN_RST;
    off_centre_ms = '0;
    below_four_ms = '0;
    dashing       = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, at reset settings (centre 511 for a full supply).
    push_beat(1023,  511,  511);  // both centred, below-4 timer starts
    push_beat(1023,    0,  511);  // hard left after a short quiet spell: dash starts
    push_beat(1023,    0, 1023);  // dash held, up doubled too
    push_beat(1023,  511,  511);  // sum drops: dash ends
    push_beat(1023,  100,  511);  // middle level only, sum three
    push_beat(1023,  300,  873);  // near plus middle, sum exactly four
    push_beat(1023,  700,  511);  // near on the high side
    push_beat(1023,  410,  611);  // just outside / on the dead zone border
    push_beat(1023,  411,  612);
    push_beat(1023,    7, 1016);  // on the edge zone borders: middle level
    push_beat(1023,    6, 1017);  // one step further: edge level
    push_beat(   0,    0,    0);  // zero supply: zones overlap, both sides light
    push_beat(   0, 1023, 1023);
    push_beat(1023, 1023,    0);
    push_beat(1023, 1023, 1023);
    push_beat(   0,  511,    0);
    push_beat(   1,    0,    1);
    push_beat( 512,  256,  256);
    queue_random(90);
    wait_drained();

    // Mid-range settings; upper data bits set on the zone writes must be dropped.
    write_all('hC32, 30, 150, 20, 1000, 600, 40);
    write_reg(REG_UNUSED, 12'h0FF);       // no such register
    queue_random(110);
    wait_drained();

    // Everything at zero: zero tick, empty window, no dash possible.
    write_all(0, 0, 0, 0, 0, 0, 0);
    queue_random(90);
    wait_drained();

    // Everything but the dash minimum at its top; all-ones data must truncate to each width.
    write_all('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF, 0);
    queue_random(90);
    wait_drained();

    // Overlapping zones (edge wider than middle), slowest tick.
    write_all(0, 600, 300, 1, 4095, 4095, 0);
    queue_random(100);
    wait_drained();

    // Fast tick against a low cap: timers overshoot the cap.
    write_all(20, 50, 100, 255, 100, 4095, 200);
    queue_random(110);
    wait_drained();

    // Random settings within the documented ranges.
    write_all($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(1, 255), $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 4095));
    queue_random(100);
    wait_drained();

    // Back to the reset values for a final stretch of gestures.
    write_all(DEAD_ZONE_RST, EDGE_ZONE_RST, MIDDLE_ZONE_RST, TICK_MS_RST,
              TIME_CAP_RST, DASH_WINDOW_RST, DASH_MIN_RST);
    queue_random(60);
    wait_drained();

    if (failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
